// ----- rtl/brp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types and constants of the byte range parser: character codes,
// parser phases, verdict codes and the records passed between the stages.
// ----------------------------------------------------------------------------
package brp_pkg;

  // width of parsed values and range offsets
  localparam int VALUE_BITS = 63;
  localparam int LEN_BITS   = VALUE_BITS + 1;
  localparam int MAX_BITS   = 16;
  localparam int CNT_BITS   = MAX_BITS + 1;

  // total size saturates at 2^VALUE_BITS
  localparam logic [LEN_BITS-1:0] SIZE_CAP = {1'b1, {VALUE_BITS{1'b0}}};

  // configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = VALUE_BITS;
  localparam logic [CFG_AW-1:0] CFG_BODY_LEN    = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_RANGE_LIMIT = 1'd1;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result item kinds
  localparam logic KIND_RANGE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic [3:0] {
    PH_START,
    PH_FIRST,
    PH_AFTER_FIRST,
    PH_AFTER_DASH,
    PH_SUFFIX_DIGIT,
    PH_SECOND,
    PH_AFTER_SECOND,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    V_OK,
    V_NOT_SATISFIABLE,
    V_DECLINED
  } verdict_t;

  typedef enum logic {
    ACT_FINISH,
    ACT_ERROR
  } act_t;

  // one completed spec or a syntax error, from the parser to accounting
  typedef struct packed {
    act_t                  act;
    logic                  term;
    logic                  nonempty;
    logic [VALUE_BITS-1:0] rstart;
    logic [VALUE_BITS-1:0] rend;
    logic [VALUE_BITS-1:0] rlen;
  } spec_t;

  // one result item
  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] range_start;
    logic [VALUE_BITS-1:0] range_end;
    verdict_t              verdict;
    logic                  last;
  } res_t;

  // up to two result items written to the output queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    res_t       e0;
    res_t       e1;
  } push_t;

endpackage
`default_nettype wire

// ----- rtl/brp_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brp_in_if
// Byte channel into the range parser: valid/ready and one character.
// ----------------------------------------------------------------------------
interface brp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface
`default_nettype wire

// ----- rtl/brp_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brp_out_if
// Result channel of the range parser: valid/ready and one range or verdict.
// ----------------------------------------------------------------------------
interface brp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [brp_pkg::VALUE_BITS-1:0] range_start;
  logic [brp_pkg::VALUE_BITS-1:0] range_end;
  logic [1:0]                     verdict;
  logic                           last;

  modport source (output valid, output kind, output range_start, output range_end,
                  output verdict, output last, input ready);
  modport sink   (input valid, input kind, input range_start, input range_end,
                  input verdict, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/brp_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brp_parse
// Input byte register and grammar state machine. Accumulates decimal values
// and, at a separator, works out the clipped range of the spec; a bad character gives an error record.
// ----------------------------------------------------------------------------
module brp_parse (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [7:0]                     in_ch,
  output logic                           in_ready,
  input  logic [brp_pkg::VALUE_BITS-1:0] body_len,
  output logic                           spec_valid,
  output brp_pkg::spec_t                 spec,
  input  logic                           spec_ready
);

  localparam int VB = brp_pkg::VALUE_BITS;

  logic                 byte_vld_r, byte_vld_nxt;
  logic [7:0]           byte_r;
  brp_pkg::phase_t      phase_r, phase_nxt;
  logic [VB-1:0]        first_r, first_nxt;
  logic [VB-1:0]        second_r, second_nxt;
  logic                 suffix_r, suffix_nxt;
  logic                 spec_vld_r, spec_vld_nxt;
  brp_pkg::spec_t       spec_r, spec_nxt;

  logic                 adv;
  logic                 is_sp, is_dash, is_comma, is_nul, is_dig, is_sep;
  logic [VB-1:0]        dval;
  logic [VB-1:0]        acc_src;
  logic [VB+3:0]        prod;
  logic                 ovf;
  logic                 ok_ch, fin, err, load_spec;

  logic [VB:0]          d_open, d_suf, d_ge, d_closed;
  logic                 open_ne, suf_gt, ge, closed_ne;
  logic [VB-1:0]        e_closed;

  // stage moves when the spec register is free or draining
  assign adv        = byte_vld_r && (!spec_vld_r || spec_ready);
  assign in_ready   = !byte_vld_r || adv;
  assign spec_valid = spec_vld_r;
  assign spec       = spec_r;

  // character classes
  assign is_sp    = (byte_r == brp_pkg::CH_SPACE);
  assign is_dash  = (byte_r == brp_pkg::CH_DASH);
  assign is_comma = (byte_r == brp_pkg::CH_COMMA);
  assign is_nul   = (byte_r == brp_pkg::CH_NUL);
  assign is_dig   = (byte_r >= brp_pkg::CH_ZERO) && (byte_r <= brp_pkg::CH_NINE);
  assign is_sep   = is_comma || is_nul;
  assign dval     = VB'(byte_r[3:0]);

  // value times ten plus digit, overflow when any bit above the value width is set
  assign acc_src = (phase_r == brp_pkg::PH_FIRST) ? first_r : second_r;
  assign prod    = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0} + (VB+4)'(byte_r[3:0]);
  assign ovf     = |prod[VB+3:VB];

  // range arithmetic for the three spec forms, all in parallel
  always_comb begin
    d_open    = {1'b0, body_len} - {1'b0, first_r};
    open_ne   = !d_open[VB] && (d_open[VB-1:0] != '0);
    d_suf     = {1'b0, body_len} - {1'b0, second_r};
    suf_gt    = d_suf[VB];
    d_ge      = {1'b0, second_r} - {1'b0, body_len};
    ge        = !d_ge[VB];
    e_closed  = ge ? body_len : (second_r + VB'(1));
    d_closed  = {1'b0, e_closed} - {1'b0, first_r};
    closed_ne = !d_closed[VB] && (d_closed[VB-1:0] != '0);
  end

  // grammar decode: legal character per phase, spec end, syntax error
  always_comb begin
    case (phase_r)
      brp_pkg::PH_START:        ok_ch = is_sp || is_dash || is_dig;
      brp_pkg::PH_FIRST:        ok_ch = (is_dig && !ovf) || is_sp || is_dash;
      brp_pkg::PH_AFTER_FIRST:  ok_ch = is_sp || is_dash;
      brp_pkg::PH_AFTER_DASH:   ok_ch = is_sp || is_sep || is_dig;
      brp_pkg::PH_SUFFIX_DIGIT: ok_ch = is_dig;
      brp_pkg::PH_SECOND:       ok_ch = (is_dig && !ovf) || is_sp || is_sep;
      brp_pkg::PH_AFTER_SECOND: ok_ch = is_sp || is_sep;
      default:                  ok_ch = 1'b1;
    endcase
    fin = is_sep && ((phase_r == brp_pkg::PH_AFTER_DASH) ||
                     (phase_r == brp_pkg::PH_SECOND) ||
                     (phase_r == brp_pkg::PH_AFTER_SECOND));
    err = !ok_ch;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (adv) begin
      if (err) begin
        phase_nxt = brp_pkg::PH_DONE;
      end else if (fin) begin
        phase_nxt = is_nul ? brp_pkg::PH_DONE : brp_pkg::PH_START;
      end else begin
        case (phase_r)
          brp_pkg::PH_START: begin
            if (is_dash) phase_nxt = brp_pkg::PH_SUFFIX_DIGIT;
            else if (is_dig) phase_nxt = brp_pkg::PH_FIRST;
          end
          brp_pkg::PH_FIRST: begin
            if (is_sp) phase_nxt = brp_pkg::PH_AFTER_FIRST;
            else if (is_dash) phase_nxt = brp_pkg::PH_AFTER_DASH;
          end
          brp_pkg::PH_AFTER_FIRST: begin
            if (is_dash) phase_nxt = brp_pkg::PH_AFTER_DASH;
          end
          brp_pkg::PH_AFTER_DASH: begin
            if (is_dig) phase_nxt = brp_pkg::PH_SECOND;
          end
          brp_pkg::PH_SUFFIX_DIGIT: begin
            phase_nxt = brp_pkg::PH_SECOND;
          end
          brp_pkg::PH_SECOND: begin
            if (is_sp) phase_nxt = brp_pkg::PH_AFTER_SECOND;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // value registers and spec record
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    suffix_nxt = suffix_r;
    load_spec  = adv && (fin || err);

    if (adv && !err) begin
      if (fin) begin
        if (is_comma) begin
          first_nxt  = '0;
          second_nxt = '0;
          suffix_nxt = 1'b0;
        end
      end else begin
        case (phase_r)
          brp_pkg::PH_START: begin
            if (is_dash) suffix_nxt = 1'b1;
            else if (is_dig) first_nxt = dval;
          end
          brp_pkg::PH_FIRST: begin
            if (is_dig) first_nxt = prod[VB-1:0];
          end
          brp_pkg::PH_AFTER_DASH, brp_pkg::PH_SUFFIX_DIGIT: begin
            if (is_dig) second_nxt = dval;
          end
          brp_pkg::PH_SECOND: begin
            if (is_dig) second_nxt = prod[VB-1:0];
          end
          default: first_nxt = first_r;
        endcase
      end
    end

    spec_nxt.act  = err ? brp_pkg::ACT_ERROR : brp_pkg::ACT_FINISH;
    spec_nxt.term = is_nul;
    if (phase_r == brp_pkg::PH_AFTER_DASH) begin
      // start to end of content
      spec_nxt.nonempty = open_ne;
      spec_nxt.rstart   = first_r;
      spec_nxt.rend     = body_len;
      spec_nxt.rlen     = d_open[VB-1:0];
    end else if (suffix_r) begin
      // last bytes, a suffix longer than the content starts at zero
      spec_nxt.nonempty = suf_gt ? (body_len != '0) : (second_r != '0);
      spec_nxt.rstart   = suf_gt ? '0 : d_suf[VB-1:0];
      spec_nxt.rend     = body_len;
      spec_nxt.rlen     = suf_gt ? body_len : second_r;
    end else begin
      // start to inclusive end, clipped
      spec_nxt.nonempty = closed_ne;
      spec_nxt.rstart   = first_r;
      spec_nxt.rend     = e_closed;
      spec_nxt.rlen     = d_closed[VB-1:0];
    end
    if (err) spec_nxt.nonempty = 1'b0;

    spec_vld_nxt = load_spec ? 1'b1 : (spec_ready ? 1'b0 : spec_vld_r);
    byte_vld_nxt = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : byte_vld_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      phase_r    <= brp_pkg::PH_START;
      first_r    <= '0;
      second_r   <= '0;
      suffix_r   <= 1'b0;
      spec_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      phase_r    <= phase_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      suffix_r   <= suffix_nxt;
      spec_vld_r <= spec_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_r <= in_ch;
    if (load_spec) spec_r <= spec_nxt;
  end

  // a finished header keeps the parser idle until reset
  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == brp_pkg::PH_DONE |=> phase_r == brp_pkg::PH_DONE)
    else $error("parser left the done phase");

endmodule
`default_nettype wire

// ----- rtl/brp_acct.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brp_acct
// Range accounting: counts and sums emitted ranges, builds the range and
// verdict items and latches the first verdict.
// ----------------------------------------------------------------------------
module brp_acct (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           spec_valid,
  input  brp_pkg::spec_t                 spec,
  output logic                           spec_ready,
  input  logic [brp_pkg::VALUE_BITS-1:0] body_len,
  input  logic [brp_pkg::MAX_BITS-1:0]   range_limit,
  input  logic                           space_ok,
  output brp_pkg::push_t                 push
);

  localparam int VB = brp_pkg::VALUE_BITS;
  localparam int LB = brp_pkg::LEN_BITS;
  localparam int CB = brp_pkg::CNT_BITS;

  logic [CB-1:0]     cnt_r, cnt_nxt;
  logic [LB-1:0]     total_r, total_nxt;
  logic              vset_r, vset_nxt;

  logic              take;
  logic [VB-1:0]     add_len;
  logic [LB:0]       sum;
  logic [CB-1:0]     cnt_inc;
  logic              too_many, over;
  logic              want_range, want_verd;
  brp_pkg::verdict_t verd;
  brp_pkg::res_t     range_item, verd_item;

  // space for two items is needed before a spec is taken
  assign spec_ready = space_ok;
  assign take       = spec_valid && spec_ready && !vset_r;

  // running count and saturating total
  always_comb begin
    add_len  = spec.nonempty ? spec.rlen : '0;
    sum      = {1'b0, total_r} + (LB+1)'(add_len);
    cnt_inc  = cnt_r + CB'(spec.nonempty);
    too_many = spec.nonempty && (cnt_inc > CB'(range_limit));
    over     = sum > (LB+1)'(body_len);
  end

  // item selection
  always_comb begin
    want_range = 1'b0;
    want_verd  = 1'b0;
    verd       = brp_pkg::V_OK;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    vset_nxt   = vset_r;

    if (take) begin
      case (spec.act)
        brp_pkg::ACT_ERROR: begin
          want_verd = 1'b1;
          verd      = brp_pkg::V_NOT_SATISFIABLE;
        end
        brp_pkg::ACT_FINISH: begin
          want_range = spec.nonempty;
          cnt_nxt    = cnt_inc;
          total_nxt  = (sum > (LB+1)'(brp_pkg::SIZE_CAP)) ? brp_pkg::SIZE_CAP : sum[LB-1:0];
          if (too_many) begin
            want_verd = 1'b1;
            verd      = brp_pkg::V_DECLINED;
          end else if (spec.term) begin
            want_verd = 1'b1;
            if (cnt_inc == '0) verd = brp_pkg::V_NOT_SATISFIABLE;
            else if (over) verd = brp_pkg::V_DECLINED;
            else verd = brp_pkg::V_OK;
          end
        end
        default: want_verd = 1'b0;
      endcase
      vset_nxt = want_verd;
    end

    range_item.kind        = brp_pkg::KIND_RANGE;
    range_item.range_start = spec.rstart;
    range_item.range_end   = spec.rend;
    range_item.verdict     = brp_pkg::V_OK;
    range_item.last        = 1'b0;

    verd_item.kind         = brp_pkg::KIND_VERDICT;
    verd_item.range_start  = '0;
    verd_item.range_end    = '0;
    verd_item.verdict      = verd;
    verd_item.last         = 1'b1;

    // range goes first when both are produced
    push.n  = 2'(want_range) + 2'(want_verd);
    push.e0 = want_range ? range_item : verd_item;
    push.e1 = verd_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
      vset_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      vset_r  <= vset_nxt;
    end
  end

  // nothing leaves once a verdict has gone out
  a_quiet_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    vset_r |-> push.n == 2'd0)
    else $error("result produced after verdict");

  // a pair is always a range followed by its verdict
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> (push.e0.kind == brp_pkg::KIND_RANGE) &&
                       (push.e1.kind == brp_pkg::KIND_VERDICT))
    else $error("bad item order in pair");

endmodule
`default_nettype wire

// ----- rtl/brp_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brp_out_fifo
// Small result queue: takes up to two items a cycle, hands out one.
// ----------------------------------------------------------------------------
module brp_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  brp_pkg::push_t push,
  output logic           space_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output brp_pkg::res_t  out_item
);

  localparam int AW = brp_pkg::FIFO_AW;
  localparam int CW = brp_pkg::FIFO_CW;

  brp_pkg::res_t mem_r [brp_pkg::FIFO_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  // room for a range and a verdict
  assign space_ok  = cnt_r <= CW'(brp_pkg::FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rp_r];
  assign pop       = out_valid && out_ready;

  // pointer update
  always_comb begin
    wp_nxt  = wp_r + AW'(push.n);
    rp_nxt  = rp_r + AW'(pop);
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wp_r] <= push.e0;
    if (push.n == 2'd2) mem_r[wp_r + AW'(1)] <= push.e1;
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(brp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> space_ok)
    else $error("push without room");

endmodule
`default_nettype wire

// ----- rtl/http_byte_range_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_byte_range_parser
// Parses an HTTP byte range value and emits clipped ranges and a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one character of the value after the bytes= prefix per
//   transaction; a zero character ends the value. out_chan carries range
//   items (kind 0, half-open [range_start, range_end)) and one verdict item
//   (kind 1, last 1): ok, not satisfiable or declined. After the verdict
//   every further character is taken and dropped until reset. The user writes
//   body length (index 0) and range limit (index 1) on cfg while idle; the block does not enforce it.
// Throughput:
//   one character per cycle while no stall holds the input (see Stall); a
//   result passes the input register, the spec register and the result
//   queue before it shows on out_chan. A spec end may give a range and a
//   verdict, which enter the queue together and leave range first.
// Reset:
//   rst_n low clears the parser, counters, verdict latch and the queue and
//   sets the body length to 0 and the range limit to 1.
// Stall:
//   results wait in a four-entry queue; while fewer than two entries are
//   free a finished spec waits in its register, and input ready drops once
//   the next character is held behind it.
// ----------------------------------------------------------------------------
module http_byte_range_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  brp_in_if.sink                       in_chan,
  brp_out_if.source                    out_chan,
  input  logic                         cfg_we,
  input  logic [brp_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [brp_pkg::CFG_DW-1:0]   cfg_wdata
);

  logic [brp_pkg::VALUE_BITS-1:0] cl_r, cl_nxt;
  logic [brp_pkg::MAX_BITS-1:0]   maxr_r, maxr_nxt;

  logic           spec_valid, spec_ready, space_ok;
  brp_pkg::spec_t spec;
  brp_pkg::push_t push;
  brp_pkg::res_t  out_item;

  // configuration registers
  always_comb begin
    cl_nxt   = cl_r;
    maxr_nxt = maxr_r;
    if (cfg_we) begin
      case (cfg_addr)
        brp_pkg::CFG_BODY_LEN:    cl_nxt = cfg_wdata;
        brp_pkg::CFG_RANGE_LIMIT: maxr_nxt = cfg_wdata[brp_pkg::MAX_BITS-1:0];
        default:                  cl_nxt = cl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r   <= '0;
      maxr_r <= brp_pkg::MAX_BITS'(1);
    end else begin
      cl_r   <= cl_nxt;
      maxr_r <= maxr_nxt;
    end
  end

  // grammar stage
  brp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ch          (in_chan.ch),
    .in_ready       (in_chan.ready),
    .body_len       (cl_r),
    .spec_valid     (spec_valid),
    .spec           (spec),
    .spec_ready     (spec_ready)
  );

  // accounting stage
  brp_acct u_acct (
    .clk            (clk),
    .rst_n          (rst_n),
    .spec_valid     (spec_valid),
    .spec           (spec),
    .spec_ready     (spec_ready),
    .body_len       (cl_r),
    .range_limit    (maxr_r),
    .space_ok       (space_ok),
    .push           (push)
  );

  // result queue
  brp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_item)
  );

  assign out_chan.kind        = out_item.kind;
  assign out_chan.range_start = out_item.range_start;
  assign out_chan.range_end   = out_item.range_end;
  assign out_chan.verdict     = out_item.verdict;
  assign out_chan.last        = out_item.last;

endmodule
`default_nettype wire

// ----- tb/sv/http_byte_range_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_byte_range_parser_tb
// Drives one long Range value through the parser, one character per
// transaction, with random bursts on the input side and a changing stall
// pattern on the result side. A behavioral copy of the parser predicts
// every range and the verdict; each result is checked field by field.
// Directed specs cover the value extremes, spaces, empty ranges and long
// suffixes, then random well-formed specs run under changing content
// lengths. The run ends with one randomly chosen verdict path and a stream
// of characters that the latched parser must drop.
// ----------------------------------------------------------------------------
module http_byte_range_parser_tb;
  import brp_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam logic [VB-1:0] VALUE_MAX = {VB{1'b1}};
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 560;

  // how the header is brought to its verdict
  typedef enum {
    END_OK,
    END_TOTAL,
    END_COUNT,
    END_SYNTAX,
    END_OVERFLOW
  } ending_t;

  // kinds of broken spec for the syntax ending
  typedef enum {
    SYN_BAD_CHAR,
    SYN_SUFFIX_SPACE,
    SYN_EMPTY_SPEC
  } syntax_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  brp_in_if  in_if ();
  brp_out_if out_if ();

  http_byte_range_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // parser copy: spec state, totals and the latched verdict
  phase_t          prs_phase;
  logic [VB-1:0]   prs_first;
  logic [VB-1:0]   prs_second;
  bit              prs_suffix;
  int unsigned     prs_count;
  logic [LEN_BITS-1:0] prs_total;
  bit              prs_done;
  logic [VB-1:0]   cl_copy;
  logic [15:0]     max_copy;

  // ranges and verdicts still owed by the block, oldest first
  res_t range_verdict_q[$];

  int bytes_sent;
  int ranges_checked;
  int verdicts_checked;
  int reg_writes;
  int mismatch_count;
  int burst_left;
  ending_t ending;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------
  function automatic void push_result(input logic kind, input logic [VB-1:0] s,
                                      input logic [VB-1:0] e, input verdict_t v);
    res_t r;
    r.kind        = kind;
    r.range_start = s;
    r.range_end   = e;
    r.verdict     = v;
    r.last        = (kind == KIND_VERDICT);
    range_verdict_q.push_back(r);
  endfunction

  function automatic void post_verdict(input verdict_t v);
    push_result(KIND_VERDICT, '0, '0, v);
    prs_done  = 1'b1;
    prs_phase = PH_DONE;
  endfunction

  // true when v*10+d still fits in the value width
  function automatic bit digit_fits(input logic [VB-1:0] v, input logic [VB-1:0] d);
    return v <= (VALUE_MAX - d) / 'd10;
  endfunction

  // spec ends on ',' or NUL: clip, emit, count, then maybe the verdict
  function automatic void close_spec(input bit open_end, input logic [7:0] term);
    logic [VB-1:0] s;
    logic [VB-1:0] e;
    if (open_end) begin
      s = prs_first;
      e = cl_copy;
    end else if (prs_suffix) begin
      s = (prs_second > cl_copy) ? '0 : cl_copy - prs_second;
      e = cl_copy;
    end else begin
      s = prs_first;
      e = (prs_second >= cl_copy) ? cl_copy : prs_second + 1'b1;
    end
    if (s < e) begin
      push_result(KIND_RANGE, s, e, V_OK);
      prs_total = prs_total + {1'b0, e - s};
      if (prs_total > SIZE_CAP) prs_total = SIZE_CAP;
      prs_count++;
      if (prs_count > max_copy) begin
        post_verdict(V_DECLINED);
        return;
      end
    end
    if (term == CH_COMMA) begin
      prs_phase  = PH_START;
      prs_first  = '0;
      prs_second = '0;
      prs_suffix = 1'b0;
      return;
    end
    if (prs_count == 0) post_verdict(V_NOT_SATISFIABLE);
    else if (prs_total > {1'b0, cl_copy}) post_verdict(V_DECLINED);
    else post_verdict(V_OK);
  endfunction

  // one accepted character through the grammar
  function automatic void parse_header_char(input logic [7:0] c);
    bit is_dig;
    bit is_sep;
    bit bad;
    logic [VB-1:0] d;
    if (prs_done) return;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    is_sep = (c == CH_COMMA) || (c == CH_NUL);
    d = VB'(c) - VB'(CH_ZERO);
    bad = 1'b0;
    case (prs_phase)
      PH_START: begin
        if (c == CH_DASH) begin
          prs_suffix = 1'b1;
          prs_phase  = PH_SUFFIX_DIGIT;
        end else if (is_dig) begin
          prs_first = d;
          prs_phase = PH_FIRST;
        end else if (c != CH_SPACE) bad = 1'b1;
      end
      PH_FIRST: begin
        if (is_dig) begin
          if (digit_fits(prs_first, d)) prs_first = prs_first * 'd10 + d;
          else bad = 1'b1;
        end else if (c == CH_SPACE) prs_phase = PH_AFTER_FIRST;
        else if (c == CH_DASH) prs_phase = PH_AFTER_DASH;
        else bad = 1'b1;
      end
      PH_AFTER_FIRST: begin
        if (c == CH_DASH) prs_phase = PH_AFTER_DASH;
        else if (c != CH_SPACE) bad = 1'b1;
      end
      PH_AFTER_DASH: begin
        if (is_sep) close_spec(1'b1, c);
        else if (is_dig) begin
          prs_second = d;
          prs_phase  = PH_SECOND;
        end else if (c != CH_SPACE) bad = 1'b1;
      end
      PH_SUFFIX_DIGIT: begin
        if (is_dig) begin
          prs_second = d;
          prs_phase  = PH_SECOND;
        end else bad = 1'b1;
      end
      PH_SECOND: begin
        if (is_dig) begin
          if (digit_fits(prs_second, d)) prs_second = prs_second * 'd10 + d;
          else bad = 1'b1;
        end else if (c == CH_SPACE) prs_phase = PH_AFTER_SECOND;
        else if (is_sep) close_spec(1'b0, c);
        else bad = 1'b1;
      end
      PH_AFTER_SECOND: begin
        if (is_sep) close_spec(1'b0, c);
        else if (c != CH_SPACE) bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) post_verdict(V_NOT_SATISFIABLE);
  endfunction

  // ------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (range_verdict_q.size() == 0) begin
        report_mismatch("result with nothing owed (kind)", out_if.kind, 0);
      end else begin
        want = range_verdict_q.pop_front();
        if (want.kind == KIND_VERDICT) verdicts_checked++;
        else ranges_checked++;
        if (out_if.kind !== want.kind) report_mismatch("kind", out_if.kind, want.kind);
        if (out_if.range_start !== want.range_start)
          report_mismatch("range_start", out_if.range_start, want.range_start);
        if (out_if.range_end !== want.range_end)
          report_mismatch("range_end", out_if.range_end, want.range_end);
        if (out_if.verdict !== want.verdict)
          report_mismatch("verdict", out_if.verdict, want.verdict);
        if (out_if.last !== want.last) report_mismatch("last", out_if.last, want.last);
      end
    end
  end

  // result side stall pattern, in a mode that is chosen again at random
  initial begin : result_sink
    int cyc;
    int mode;
    out_if.ready <= 1'b0;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cyc % 128 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        default: out_if.ready <= ((cyc % 11) >= 8);
      endcase
      cyc++;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  // one character, in bursts with random gaps
  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    parse_header_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_number(input logic [VB-1:0] v);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 2)) send_byte(CH_ZERO);
    send_text($sformatf("%0d", v));
  endtask

  task automatic maybe_spaces();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_byte(CH_SPACE);
  endtask

  // drop valid, wait for every owed result, then for the pipeline to empty
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (range_verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (a == CFG_BODY_LEN) cl_copy = d;
    else max_copy = d[15:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // offsets near the top of the content, so every range stays small
  function automatic logic [VB-1:0] pick_value();
    logic [VB-1:0] lo;
    lo = (cl_copy > VB'(4000)) ? cl_copy - VB'(4000) : '0;
    return lo + VB'($urandom_range(0, 4100));
  endfunction

  // one well-formed spec with random form, values and spacing
  task automatic send_random_spec();
    logic [VB-1:0] a;
    logic [VB-1:0] b;
    int form;
    form = $urandom_range(0, 2);
    maybe_spaces();
    case (form)
      0: begin
        a = pick_value();
        b = ($urandom_range(0, 5) == 0) ? pick_value() : a + VB'($urandom_range(0, 40));
        send_number(a);
        maybe_spaces();
        send_byte(CH_DASH);
        maybe_spaces();
        send_number(b);
        maybe_spaces();
      end
      1: begin
        send_number(pick_value());
        maybe_spaces();
        send_byte(CH_DASH);
        maybe_spaces();
      end
      default: begin
        send_byte(CH_DASH);
        send_number(VB'($urandom_range(0, 5000)));
        maybe_spaces();
      end
    endcase
    send_byte(CH_COMMA);
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  // zero content length: every range is empty and nothing comes out
  task automatic test_empty_ranges();
    send_text("0-5,-7,");
  endtask

  // long suffix at the value limit, spaces, and the top offsets
  task automatic test_directed_ranges();
    settle();
    write_reg(CFG_RANGE_LIMIT, CFG_DW'(1));
    write_reg(CFG_BODY_LEN, CFG_DW'(500));
    send_text("-9223372036854775807,");
    settle();
    write_reg(CFG_RANGE_LIMIT, CFG_DW'(16'hFFFF));
    send_text(" 7 - ,");
    settle();
    write_reg(CFG_BODY_LEN, CFG_DW'(VALUE_MAX));
    send_text("9223372036854775806-,");
  endtask

  // random specs in phases, each under its own content length
  task automatic test_random_specs();
    int start_count;
    int pick;
    logic [VB-1:0] cl;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      settle();
      pick = $urandom_range(0, 9);
      if (pick == 0) cl = '0;
      else if (pick == 1) cl = VALUE_MAX;
      else if (pick < 4) cl = VB'({$urandom(), $urandom()});
      else cl = VB'($urandom_range(1, 3000));
      write_reg(CFG_BODY_LEN, cl);
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_RANGE_LIMIT, CFG_DW'(prs_count + $urandom_range(200, 2000)));
      repeat ($urandom_range(3, 12)) send_random_spec();
    end
  endtask

  // one way of ending the header, chosen at random
  task automatic test_final_verdict();
    syntax_t syn;
    logic [7:0] c;
    settle();
    ending = ending_t'($urandom_range(0, 4));
    case (ending)
      END_OK: begin
        write_reg(CFG_BODY_LEN, CFG_DW'(VALUE_MAX));
        send_text("1-1");
        send_byte(CH_NUL);
      end
      END_TOTAL: begin
        write_reg(CFG_BODY_LEN, CFG_DW'(1));
        send_text("0-0");
        send_byte(CH_NUL);
      end
      END_COUNT: begin
        write_reg(CFG_BODY_LEN, CFG_DW'(1000));
        write_reg(CFG_RANGE_LIMIT, ($urandom_range(0, 1) == 1) ?
                  CFG_DW'(prs_count) : CFG_DW'($urandom_range(0, 1)));
        send_text("0-,");
      end
      END_SYNTAX: begin
        syn = syntax_t'($urandom_range(0, 2));
        case (syn)
          SYN_BAD_CHAR: begin
            do c = 8'($urandom_range(0, 255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_DASH);
            send_text("12");
            send_byte(c);
          end
          SYN_SUFFIX_SPACE: send_text("- 5");
          default: send_byte(CH_NUL);
        endcase
      end
      default: send_text("9223372036854775808,");
    endcase
  endtask

  // after the verdict every character is taken and dropped
  task automatic test_after_verdict();
    send_byte(8'hFF);
    send_text("1-2,");
    send_byte(CH_NUL);
    repeat (40) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.ch    <= CH_NUL;
    cfg_we      <= 1'b0;
    cfg_addr    <= CFG_BODY_LEN;
    cfg_wdata   <= '0;
    prs_phase  = PH_START;
    prs_first  = '0;
    prs_second = '0;
    prs_suffix = 1'b0;
    prs_count  = 0;
    prs_total  = '0;
    prs_done   = 1'b0;
    cl_copy    = '0;
    max_copy   = 16'd1;
    bytes_sent = 0;
    ranges_checked = 0;
    verdicts_checked = 0;
    reg_writes = 0;
    mismatch_count = 0;
    burst_left = 0;
    ending = END_OK;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ranges();
    test_directed_ranges();
    test_random_specs();
    test_final_verdict();
    test_after_verdict();

    // drain
    in_if.valid <= 1'b0;
    while (range_verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d characters, checked %0d ranges and %0d verdicts, %0d register writes",
             bytes_sent, ranges_checked, verdicts_checked, reg_writes);
    $display("header ended by %s, %0d mismatches", ending.name(), mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
